[src/i2cee_pkg.sv]
// Shared types, constants and helpers for the I2C slave EEPROM emulator backend.
// Used by i2cee_ctrl, i2cee_store, the top level and the checker; no dependencies.

package i2cee_pkg;

	localparam int STORE_DEPTH = 64;
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int DATA_W      = 8;
	localparam int CFG_DW      = 32;
	localparam int PADDR_W     = 3;

	// Register index, byte address / 4
	localparam logic [0:0] REG_SLAVE_ENABLE = 1'b0;

	typedef enum logic [2:0] {
		ACT_RX      = 3'd0,
		ACT_DRAIN   = 3'd1,
		ACT_RD_REQ  = 3'd2,
		ACT_RD_DONE = 3'd3,
		ACT_STOP    = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		XS_IDLE  = 3'b001,
		XS_READ  = 3'b010,
		XS_WRITE = 3'b100
	} xfer_t;

	// Store access request from the control logic
	typedef struct packed {
		logic              wr_en;
		logic              rd_en;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] wdata;
	} store_req_t;

	// Byte modulo the store depth: the depth is a power of two, keep the low bits
	function automatic logic [ADDR_W-1:0] byte_mod_depth(input logic [DATA_W-1:0] v);
		return v[ADDR_W-1:0];
	endfunction

	// Pointer advance with wrap at the store depth
	function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
		logic [ADDR_W-1:0] n;
		if (p == ADDR_W'(STORE_DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + ADDR_W'(1);
		end
		return n;
	endfunction

endpackage

[src/i2cee_ctrl.sv]
// Transfer control of the EEPROM emulator: pointer, first-byte mode, transfer state.
// Decodes one bus event per accepted item into a store request; uses i2cee_pkg.

module i2cee_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  logic [2:0]                  action,
	input  logic [i2cee_pkg::DATA_W-1:0] data,
	input  logic                        slave_active,
	output i2cee_pkg::store_req_t       req
);

	logic [i2cee_pkg::ADDR_W-1:0] ptr_q, ptr_d;
	logic                         fbm_q, fbm_d, fbm_eff, wb;
	i2cee_pkg::xfer_t             xs_q, xs_d;

	always_comb begin
		ptr_d     = ptr_q;
		fbm_d     = fbm_q;
		xs_d      = xs_q;
		fbm_eff   = fbm_q;
		wb        = 1'b0;
		req.wr_en = 1'b0;
		req.rd_en = 1'b0;
		req.addr  = ptr_q;
		req.wdata = data;
		if (take) begin
			unique case (i2cee_pkg::action_t'(action))
				i2cee_pkg::ACT_RX: begin
					// open a write transfer unless one is running
					if (xs_q != i2cee_pkg::XS_WRITE) begin
						xs_d    = i2cee_pkg::XS_WRITE;
						fbm_eff = 1'b1;
					end
					wb = 1'b1;
				end
				i2cee_pkg::ACT_DRAIN: begin
					wb = 1'b1;
				end
				i2cee_pkg::ACT_RD_REQ: begin
					if (slave_active) begin
						xs_d      = i2cee_pkg::XS_READ;
						req.rd_en = 1'b1;
					end
				end
				i2cee_pkg::ACT_RD_DONE: begin
					ptr_d = i2cee_pkg::ptr_inc(ptr_q);
				end
				i2cee_pkg::ACT_STOP: begin
					xs_d  = i2cee_pkg::XS_IDLE;
					fbm_d = 1'b1;
				end
				default: begin
				end
			endcase
		end
		if (wb) begin
			if (fbm_eff) begin
				ptr_d = i2cee_pkg::byte_mod_depth(data);
				fbm_d = 1'b0;
			end else begin
				req.wr_en = 1'b1;
				ptr_d     = i2cee_pkg::ptr_inc(ptr_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			fbm_q <= 1'b0;
			xs_q  <= i2cee_pkg::XS_IDLE;
		end else begin
			ptr_q <= ptr_d;
			fbm_q <= fbm_d;
			xs_q  <= xs_d;
		end
	end

endmodule

[src/i2cee_store.sv]
// Byte store of the EEPROM emulator: memory, per-entry valid bits, registered read.
// An entry never written since reset reads as zero; uses i2cee_pkg.

module i2cee_store (
	input  logic                         clk,
	input  logic                         arst_n,
	input  i2cee_pkg::store_req_t        req,
	output logic [i2cee_pkg::DATA_W-1:0] rdata
);

	logic [i2cee_pkg::DATA_W-1:0]    mem [i2cee_pkg::STORE_DEPTH];
	logic [i2cee_pkg::STORE_DEPTH-1:0] vld_q;
	logic [i2cee_pkg::DATA_W-1:0]    rdata_q;
	logic                            hit_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rdata_q <= mem[req.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.addr] <= 1'b1;
			end
			if (req.rd_en) begin
				hit_q <= vld_q[req.addr];
			end
		end
	end

	assign rdata = hit_q ? rdata_q : '0;

endmodule

[src/i2c_slave_eeprom_emulator.sv]
// Top level of the I2C slave EEPROM emulator backend.
// Instantiates i2cee_ctrl and i2cee_store; uses i2cee_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one bus event per item:
//   action, data and slave_active. Output channel (out_valid / out_stall)
//   carries tx_byte, one item for every served read request (action read
//   request with slave_active set while slave_enable is one).
//   Latency: a result appears on out_valid the cycle after its event is
//   accepted. Throughput: one event per cycle while in_stall is low; each
//   event makes at most one store read or write and may update the pointer.
//   Stall: in_stall rises only while a result waits and out_stall is high;
//   the waiting tx_byte holds until it is taken. As soon as the result
//   drains, a new event may enter in the same cycle.
//   Reset (arst_n low): pointer zero, first-byte mode clear, transfer
//   idle, slave_enable zero, every store entry reads as zero (per-entry
//   valid bits, no clearing pass), no result pending.
//   Configuration: APB write to byte address 0 sets slave_enable; with it
//   zero, events are accepted and dropped. pready is always high.

module i2c_slave_eeprom_emulator (
	input  logic                           clk,
	input  logic                           arst_n,
	// event input
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [2:0]                     action,
	input  logic [i2cee_pkg::DATA_W-1:0]   data,
	input  logic                           slave_active,
	// result output
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [i2cee_pkg::DATA_W-1:0]   tx_byte,
	// configuration
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [i2cee_pkg::PADDR_W-1:0]  paddr,
	input  logic [i2cee_pkg::CFG_DW-1:0]   pwdata,
	output logic [i2cee_pkg::CFG_DW-1:0]   prdata,
	output logic                           pready
);

	logic                  enable_q;
	logic                  out_valid_q;
	logic                  accept;
	logic                  reg_sel;
	i2cee_pkg::store_req_t req;

	// Config register decode: index is the word address
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2:2] == i2cee_pkg::REG_SLAVE_ENABLE);
	assign prdata  = reg_sel ? {{(i2cee_pkg::CFG_DW-1){1'b0}}, enable_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			enable_q <= pwdata[0];
		end
	end

	// Hold new events only while a result waits on a stalled receiver
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	i2cee_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (accept && enable_q),
		.action       (action),
		.data         (data),
		.slave_active (slave_active),
		.req          (req)
	);

	i2cee_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rdata  (tx_byte)
	);

	// Result slot: fill on a served read, drain when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (req.rd_en) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[src/i2cee_chk.sv]
// Port-level checker for the I2C slave EEPROM emulator top level.
// Bound to i2c_slave_eeprom_emulator; uses i2cee_pkg.

module i2cee_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic [2:0]                     action,
	input logic                           slave_active,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [i2cee_pkg::DATA_W-1:0]   tx_byte
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(tx_byte))
		else $error("stalled result changed or dropped");

	// A new result only follows an accepted, active read request
	a_rise_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall && slave_active &&
			action == i2cee_pkg::ACT_RD_REQ))
		else $error("result without read request");

	// Any other accepted event leaves no result behind
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && action != i2cee_pkg::ACT_RD_REQ |=> !out_valid)
		else $error("result from non-read event");

	// A taken result is not repeated without a new event
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !(in_valid && !in_stall) |=> !out_valid)
		else $error("result repeated");

	// Input is only held back by a waiting, stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without pending result");

endmodule

bind i2c_slave_eeprom_emulator i2cee_chk u_chk (.*);

[verif/tb_i2c_slave_eeprom_emulator.sv]
// Self-checking testbench for the I2C slave EEPROM emulator backend: bus events in, tx bytes out.
// Predicts every tx byte from its own store, pointer and transfer model and checks each one.
// Depends on i2cee_pkg and i2c_slave_eeprom_emulator; nothing else.

module tb_i2c_slave_eeprom_emulator;
	timeunit 1ns;
	timeprecision 1ps;

	// Generous ceiling: roughly 2k events plus hold-offs.
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_EVENTS = 620;
	localparam int SETTLE_CYCLES = 8;

	logic                            clk;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_stall;
	logic [2:0]                      action;
	logic [i2cee_pkg::DATA_W-1:0]    data;
	logic                            slave_active;
	logic                            out_valid;
	logic                            out_stall;
	logic [i2cee_pkg::DATA_W-1:0]    tx_byte;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [i2cee_pkg::PADDR_W-1:0]   paddr;
	logic [i2cee_pkg::CFG_DW-1:0]    pwdata;
	logic [i2cee_pkg::CFG_DW-1:0]    prdata;
	logic                            pready;

	// Shadow of the emulated EEPROM and its control state
	logic [i2cee_pkg::DATA_W-1:0]    store_model [i2cee_pkg::STORE_DEPTH];
	logic [i2cee_pkg::ADDR_W-1:0]    pointer_model;
	logic                            first_byte_model;
	i2cee_pkg::xfer_t                xfer_model;
	logic                            enable_model;

	// Bytes the block owes us, oldest first
	logic [i2cee_pkg::DATA_W-1:0]    tx_expected [$];
	logic [i2cee_pkg::DATA_W-1:0]    want_byte;

	int mismatches;
	int events_applied;
	int cycle_count;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;

	i2c_slave_eeprom_emulator i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.data         (data),
		.slave_active (slave_active),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.tx_byte      (tx_byte),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// 4 ns clock: high half, then low half
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Abort on a hang; a missing result ends up here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Receiver: a pending hold-off wins, otherwise stall at the current idle rate.
	// The hold-off counts down here, once per falling edge.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at cycle %0d: %s: got %0h, want %0h", cycle_count, what, got, want);
		mismatches++;
	endtask

	// Compare every taken tx byte against the oldest expectation.
	// Sampling at the rising edge sees the values from before the edge.
	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			if (tx_expected.size() == 0) begin
				report_mismatch("tx byte with nothing expected", 32'(tx_byte), '0);
			end else begin
				want_byte = tx_expected.pop_front();
				if (tx_byte !== want_byte) begin
					report_mismatch("tx_byte", 32'(tx_byte), 32'(want_byte));
				end
			end
		end
	end

	// Store one write byte: first byte of a transfer loads the pointer, later ones land
	// at the pointer and advance it with wrap at the store depth.
	function automatic void take_byte(input logic [i2cee_pkg::DATA_W-1:0] d);
		if (first_byte_model) begin
			pointer_model = i2cee_pkg::ADDR_W'(int'(d) % i2cee_pkg::STORE_DEPTH);
			first_byte_model = 1'b0;
		end else begin
			store_model[pointer_model] = d;
			pointer_model = i2cee_pkg::ADDR_W'((int'(pointer_model) + 1) %
				i2cee_pkg::STORE_DEPTH);
		end
	endfunction

	// Apply one accepted event to the shadow state; queue the tx byte if one is due.
	// Returns one when the event had any effect at all.
	function automatic bit predict_event(input logic [2:0] act,
			input logic [i2cee_pkg::DATA_W-1:0] d, input logic act_bit);
		if (!enable_model) begin
			return 1'b0;
		end
		case (act)
			i2cee_pkg::ACT_RX: begin
				// a byte outside a write transfer opens one and re-arms address capture
				if (xfer_model != i2cee_pkg::XS_WRITE) begin
					xfer_model = i2cee_pkg::XS_WRITE;
					first_byte_model = 1'b1;
				end
				take_byte(d);
			end
			i2cee_pkg::ACT_DRAIN: begin
				take_byte(d);
			end
			i2cee_pkg::ACT_RD_REQ: begin
				if (!act_bit) begin
					return 1'b0;
				end
				xfer_model = i2cee_pkg::XS_READ;
				tx_expected.push_back(store_model[pointer_model]);
			end
			i2cee_pkg::ACT_RD_DONE: begin
				pointer_model = i2cee_pkg::ADDR_W'((int'(pointer_model) + 1) %
					i2cee_pkg::STORE_DEPTH);
			end
			i2cee_pkg::ACT_STOP: begin
				xfer_model = i2cee_pkg::XS_IDLE;
				first_byte_model = 1'b1;
			end
			default: begin
				return 1'b0;
			end
		endcase
		return 1'b1;
	endfunction

	// Offer one item after a random gap and hold it until the block takes it.
	// Valid is only ever set once per falling edge, so back-to-back items keep it high.
	task automatic send_event(input logic [2:0] act, input logic [i2cee_pkg::DATA_W-1:0] d,
			input logic act_bit);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		action       <= act;
		data         <= d;
		slave_active <= act_bit;
		do @(posedge clk); while (in_stall !== 1'b0);
		events_applied += predict_event(act, d, act_bit);
	endtask

	// Drop valid and wait until every owed byte has come, then let the block settle.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tx_expected.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write of slave_enable, then read it back in a second transfer.
	task automatic write_enable(input logic v);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {i2cee_pkg::REG_SLAVE_ENABLE, 2'b00};
		pwdata  <= i2cee_pkg::CFG_DW'(v);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		enable_model = v;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== i2cee_pkg::CFG_DW'(v)) begin
			report_mismatch("slave_enable read back", prdata, i2cee_pkg::CFG_DW'(v));
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// One random transaction: mostly well-formed writes and reads, some drains and noise.
	task automatic random_transfer();
		int kind;
		int n;
		kind = $urandom_range(99);
		if (kind < 40) begin
			// write: address byte, data bytes, usually a stop
			send_event(i2cee_pkg::ACT_RX, i2cee_pkg::DATA_W'($urandom), 1'($urandom));
			n = $urandom_range(8, 1);
			repeat (n) send_event(i2cee_pkg::ACT_RX, i2cee_pkg::DATA_W'($urandom),
				1'($urandom));
			if ($urandom_range(9) != 0) begin
				send_event(i2cee_pkg::ACT_STOP, i2cee_pkg::DATA_W'($urandom), 1'($urandom));
			end
		end else if (kind < 75) begin
			// random read: optional address set, then sequential reads
			if ($urandom_range(1) != 0) begin
				send_event(i2cee_pkg::ACT_RX, i2cee_pkg::DATA_W'($urandom), 1'($urandom));
			end
			n = $urandom_range(6, 1);
			repeat (n) begin
				send_event(i2cee_pkg::ACT_RD_REQ, i2cee_pkg::DATA_W'($urandom), 1'b1);
				send_event(i2cee_pkg::ACT_RD_DONE, i2cee_pkg::DATA_W'($urandom),
					1'($urandom));
			end
			send_event(i2cee_pkg::ACT_STOP, i2cee_pkg::DATA_W'($urandom), 1'($urandom));
		end else if (kind < 85) begin
			n = $urandom_range(4, 1);
			repeat (n) send_event(i2cee_pkg::ACT_DRAIN, i2cee_pkg::DATA_W'($urandom),
				1'($urandom));
		end else begin
			// noise: any code, including the unused ones and inactive reads
			n = $urandom_range(3, 1);
			repeat (n) send_event(3'($urandom_range(7)), i2cee_pkg::DATA_W'($urandom),
				1'($urandom));
		end
	endtask

	// Events while disabled must change nothing and produce nothing.
	task automatic test_disabled();
		write_enable(1'b0);
		send_event(i2cee_pkg::ACT_RX, 8'h05, 1'b1);
		send_event(i2cee_pkg::ACT_RD_REQ, 8'h00, 1'b1);
		send_event(i2cee_pkg::ACT_DRAIN, 8'hff, 1'b0);
		send_event(i2cee_pkg::ACT_RD_DONE, 8'h00, 1'b1);
		send_event(i2cee_pkg::ACT_STOP, 8'h00, 1'b1);
		wait_idle();
		write_enable(1'b1);
	endtask

	// Hand-picked walk: reset contents, inactive read, pointer wrap on write and on
	// read done, address byte modulo depth, drains after a stop, unused codes.
	task automatic test_directed();
		send_event(i2cee_pkg::ACT_RD_REQ, 8'h00, 1'b1);
		send_event(i2cee_pkg::ACT_RD_REQ, 8'hff, 1'b0);
		send_event(i2cee_pkg::ACT_DRAIN, 8'h5a, 1'b0);
		send_event(i2cee_pkg::ACT_RX, 8'hff, 1'b1);
		send_event(i2cee_pkg::ACT_RX, 8'ha5, 1'b0);
		send_event(i2cee_pkg::ACT_RX, 8'h00, 1'b1);
		send_event(i2cee_pkg::ACT_STOP, 8'h00, 1'b0);
		send_event(i2cee_pkg::ACT_RX, 8'h3f, 1'b1);
		send_event(i2cee_pkg::ACT_STOP, 8'hff, 1'b1);
		send_event(i2cee_pkg::ACT_RD_REQ, 8'h00, 1'b1);
		send_event(i2cee_pkg::ACT_RD_DONE, 8'h00, 1'b1);
		send_event(i2cee_pkg::ACT_RD_REQ, 8'h00, 1'b1);
		send_event(i2cee_pkg::ACT_RD_DONE, 8'hff, 1'b0);
		send_event(i2cee_pkg::ACT_DRAIN, 8'h81, 1'b1);
		send_event(i2cee_pkg::ACT_DRAIN, 8'hff, 1'b1);
		send_event(i2cee_pkg::ACT_STOP, 8'h00, 1'b1);
		send_event(i2cee_pkg::ACT_RX, 8'h01, 1'b0);
		send_event(i2cee_pkg::ACT_RD_REQ, 8'h00, 1'b1);
		send_event(i2cee_pkg::ACT_RX, 8'h80, 1'b1);
		send_event(i2cee_pkg::ACT_RD_REQ, 8'hff, 1'b0);
		for (int c = i2cee_pkg::ACT_STOP + 1; c < 8; c++) begin
			send_event(3'(c), 8'hff, 1'b1);
		end
		send_event(i2cee_pkg::ACT_STOP, 8'h00, 1'b0);
		wait_idle();
	endtask

	task automatic test_random_phase(input int send_pct, input int recv_pct, input int target);
		int goal;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		goal = events_applied + target;
		while (events_applied < goal) begin
			random_transfer();
		end
		wait_idle();
	endtask

	// Flip the block off for a burst of random transfers, then back on.
	task automatic test_enable_toggle();
		write_enable(1'b0);
		repeat (10) random_transfer();
		wait_idle();
		write_enable(1'b1);
	endtask

	// Hold the receiver off for a long stretch while reads keep coming, so the
	// pending result blocks and the block stalls its input.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		@(posedge clk);
		hold_left = 80;
		repeat (16) begin
			send_event(i2cee_pkg::ACT_RD_REQ, i2cee_pkg::DATA_W'($urandom), 1'b1);
			if ($urandom_range(1) != 0) begin
				send_event(i2cee_pkg::ACT_RD_DONE, i2cee_pkg::DATA_W'($urandom),
					1'($urandom));
			end
		end
		wait_idle();
	endtask

	// Pause the sender until every owed byte is in, then carry on.
	task automatic test_drain_pause();
		send_idle_pct = 0;
		recv_idle_pct = 54;
		repeat (3) begin
			random_transfer();
			repeat (4) send_event(i2cee_pkg::ACT_RD_REQ, i2cee_pkg::DATA_W'($urandom), 1'b1);
			@(negedge clk);
			in_valid <= 1'b0;
			while (tx_expected.size() != 0) begin
				@(posedge clk);
			end
		end
		wait_idle();
	endtask

	initial begin
		int drain_wait;
		clk          = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		action       = i2cee_pkg::ACT_STOP;
		data         = '0;
		slave_active = 1'b0;
		out_stall    = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		mismatches     = 0;
		events_applied = 0;
		cycle_count    = 0;
		send_idle_pct  = 0;
		recv_idle_pct  = 0;
		hold_left      = 0;
		drain_wait     = 0;

		// reset state of the shadow: cleared store, pointer zero, idle, disabled
		foreach (store_model[i]) store_model[i] = '0;
		pointer_model    = '0;
		first_byte_model = 1'b0;
		xfer_model       = i2cee_pkg::XS_IDLE;
		enable_model     = 1'b0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_disabled();
		test_directed();
		test_random_phase(7, 54, PHASE_EVENTS);
		test_enable_toggle();
		test_random_phase(54, 7, PHASE_EVENTS);
		test_backpressure();
		test_drain_pause();
		test_random_phase(0, 0, PHASE_EVENTS);

		// final drain with a bound, then let the block settle
		@(negedge clk);
		in_valid <= 1'b0;
		while (tx_expected.size() != 0 && drain_wait < 10000) begin
			@(posedge clk);
			drain_wait++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tx_expected.size() != 0) begin
			report_mismatch("tx bytes never delivered", 32'(tx_expected.size()), '0);
		end

		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
